[design/cda_pkg.sv]
// Shared constants, codes and calendar helper functions for the date arithmetic unit.
package cda_pkg;

	// Field widths
	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int CNT_W    = 16;
	localparam int MODE_W   = 3;
	localparam int STAT_W   = 2;
	localparam int ORD_W    = 2;
	localparam int YMOD_W   = 9;

	// Stream widths
	localparam int S_DATA_W = 40;
	localparam int S_USER_W = MODE_W;
	localparam int M_DATA_W = 32;

	// Gregorian cycle: leap pattern repeats every 400 years
	localparam int                 YEAR_CYCLE      = 400;
	localparam logic [YMOD_W-1:0]  YEAR_CYCLE_LAST = YMOD_W'(YEAR_CYCLE - 1);
	localparam int                 YMOD_TOP_SHIFT  = 5;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_SET  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_NEXT = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PREV = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ADD  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SUB  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CMP  = 3'd5;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

	// Compare results
	localparam logic [ORD_W-1:0] ORD_EARLIER = 2'd0;
	localparam logic [ORD_W-1:0] ORD_EQUAL   = 2'd1;
	localparam logic [ORD_W-1:0] ORD_LATER   = 2'd2;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAYS_LONG = 5'd31;
	localparam logic [DAY_W-1:0]   DAYS_LEAP_FEB = 5'd29;

	localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// Leap test on the year reduced modulo 400
	function automatic logic is_leap(input logic [YMOD_W-1:0] r);
		return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	// Month length; months outside 1..12 count as 31 days
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [MONTH_W-1:0] idx;
		idx = m - MONTH_JAN;
		if (m < MONTH_JAN || m > MONTH_DEC)
			return DAYS_LONG;
		else if (m == MONTH_FEB && leap)
			return DAYS_LEAP_FEB;
		else
			return MONTH_DAYS[idx];
	endfunction

endpackage

[design/calendar_date_arithmetic_unit.sv]
// Top level of the Gregorian date arithmetic unit: sequencer, date registers, stream ports.
//
// Usage:
//   The unit holds one date. Each transfer on the slave stream carries one operation
//   (s_tuser) and its operands (s_tdata); exactly one result transfer follows on the
//   master stream with the stored date after the operation, a status and a compare order.
//   s_tready is high only while the sequencer is idle, so one operation is in work at a
//   time. The result sits in an output register until m_tready takes it; meanwhile the
//   next operation may already be accepted and worked on, and a finished one waits in the
//   done state until the output register is free.
// Sequence (accept to m_tvalid):
//   compare and unused modes: the done state loads the result into the output register
//   set: six shifted subtract steps reduce the year modulo 400 for the leap test
//   next/previous day, add, subtract: one adder/comparator on the day count walks a
//   month per cycle until the day fits its month, then the done state loads the
//   result.
// Reset: the stored date becomes 1 January 2000 and both streams go idle.
// Stall: a result not taken by the receiver holds m_tdata and stops the next result.
module calendar_date_arithmetic_unit #(
	parameter int MAX_YEAR   = 9999,
	parameter int COUNT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// given_day[4:0], given_month[8:5], given_year[22:9], day_count[38:23], zero[39]
	input  logic [cda_pkg::S_DATA_W-1:0] s_tdata,
	// mode[2:0]
	input  logic [cda_pkg::S_USER_W-1:0] s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// cur_day[4:0], cur_month[8:5], cur_year[22:9], status[24:23], order[26:25], zero[31:27]
	output logic [cda_pkg::M_DATA_W-1:0] m_tdata
);
	import cda_pkg::*;

	localparam int CW = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;
	// Working day must hold the stored day plus the full count, with a sign bit
	localparam int DX = (CW > DAY_W) ? CW : DAY_W;
	localparam int DW = DX + 2;
	localparam logic [YEAR_W:0]        MAX_YEAR_X = (YEAR_W + 1)'(MAX_YEAR);
	localparam logic signed [DW-1:0]   DAY_ONE    = DW'(1);
	localparam logic [YEAR_W-1:0]      YEAR_ONE   = YEAR_W'(1);
	localparam logic [YEAR_W-1:0]      RESET_YEAR = YEAR_W'(2000);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_YMOD,
		ST_FWD,
		ST_BWD,
		ST_DONE
	} state_t;

	state_t state_q;

	// Stored date and its year modulo 400
	logic [DAY_W-1:0]   stored_day_q;
	logic [MONTH_W-1:0] stored_month_q;
	logic [YEAR_W-1:0]  stored_year_q;
	logic [YMOD_W-1:0]  stored_r_q;

	// Working date while walking months
	logic signed [DW-1:0] wd_q;
	logic [MONTH_W-1:0]   wm_q;
	logic [YEAR_W-1:0]    wy_q;
	logic [YMOD_W-1:0]    wr_q;

	// Latched operands of a set
	logic [DAY_W-1:0]   g_day_q;
	logic [MONTH_W-1:0] g_month_q;
	logic [YEAR_W-1:0]  g_year_q;

	logic [STAT_W-1:0]   stat_q;
	logic [ORD_W-1:0]    ord_q;
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	// Input unpacking
	logic [MODE_W-1:0]  in_mode;
	logic [DAY_W-1:0]   in_day;
	logic [MONTH_W-1:0] in_month;
	logic [YEAR_W-1:0]  in_year;
	logic [CNT_W-1:0]   in_cnt;
	logic               accept;

	assign in_mode  = s_tuser;
	assign in_day   = s_tdata[4:0];
	assign in_month = s_tdata[8:5];
	assign in_year  = s_tdata[22:9];
	assign in_cnt   = s_tdata[38:23];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	logic signed [DW-1:0] sd_ext;
	logic signed [DW-1:0] cnt_ext;
	assign sd_ext  = $signed({{(DW - DAY_W){1'b0}}, stored_day_q});
	assign cnt_ext = $signed({{(DW - CW){1'b0}}, in_cnt[CW-1:0]});

	// Year reduction for the set check
	logic              ymod_start;
	logic              ymod_done;
	logic [YMOD_W-1:0] ymod_rem;

	assign ymod_start = accept && (in_mode == MODE_SET);

	cda_ymod u_ymod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ymod_start),
		.year   (in_year),
		.done   (ymod_done),
		.rem    (ymod_rem)
	);

	logic set_ok;
	assign set_ok = (g_month_q >= MONTH_JAN) && (g_month_q <= MONTH_DEC) &&
		(g_day_q != '0) && (g_day_q <= month_len(g_month_q, is_leap(ymod_rem))) &&
		(g_year_q >= YEAR_ONE) && ({1'b0, g_year_q} <= MAX_YEAR_X);

	// Forward month step: drop this month's length
	logic [DAY_W-1:0]     fwd_len;
	logic signed [DW-1:0] fwd_len_s;
	logic                 fwd_more;
	logic [YEAR_W:0]      wy_inc;
	logic                 fwd_over;
	logic [YMOD_W-1:0]    wr_inc;

	assign fwd_len   = month_len(wm_q, is_leap(wr_q));
	assign fwd_len_s = $signed({{(DW - DAY_W){1'b0}}, fwd_len});
	assign fwd_more  = wd_q > fwd_len_s;
	assign wy_inc    = {1'b0, wy_q} + (YEAR_W + 1)'(1);
	assign fwd_over  = wy_inc > MAX_YEAR_X;
	assign wr_inc    = (wr_q == YEAR_CYCLE_LAST) ? '0 : wr_q + YMOD_W'(1);

	// Backward month step: borrow the previous month's length
	logic                 bwd_more;
	logic                 bwd_wrap;
	logic [MONTH_W-1:0]   bwd_month;
	logic [DAY_W-1:0]     bwd_len;
	logic signed [DW-1:0] bwd_len_s;
	logic [YMOD_W-1:0]    wr_dec;

	assign bwd_more  = wd_q < DAY_ONE;
	assign bwd_wrap  = (wm_q == MONTH_JAN);
	assign bwd_month = bwd_wrap ? MONTH_DEC : wm_q - MONTH_JAN;
	assign bwd_len   = month_len(bwd_month, is_leap(wr_q));
	assign bwd_len_s = $signed({{(DW - DAY_W){1'b0}}, bwd_len});
	assign wr_dec    = (wr_q == '0) ? YEAR_CYCLE_LAST : wr_q - YMOD_W'(1);

	// Compare stored date against the raw given fields
	logic [ORD_W-1:0] cmp_ord;
	always_comb begin
		if (stored_year_q != in_year)
			cmp_ord = (stored_year_q < in_year) ? ORD_EARLIER : ORD_LATER;
		else if (stored_month_q != in_month)
			cmp_ord = (stored_month_q < in_month) ? ORD_EARLIER : ORD_LATER;
		else if (stored_day_q != in_day)
			cmp_ord = (stored_day_q < in_day) ? ORD_EARLIER : ORD_LATER;
		else
			cmp_ord = ORD_EQUAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			stored_day_q   <= DAY_W'(1);
			stored_month_q <= MONTH_JAN;
			stored_year_q  <= RESET_YEAR;
			stored_r_q     <= '0;
			wd_q           <= '0;
			wm_q           <= MONTH_JAN;
			wy_q           <= YEAR_ONE;
			wr_q           <= '0;
			g_day_q        <= '0;
			g_month_q      <= '0;
			g_year_q       <= '0;
			stat_q         <= STAT_OK;
			ord_q          <= ORD_EARLIER;
			m_tvalid_q     <= 1'b0;
			m_tdata_q      <= '0;
		end else begin
			// Release the output register once the receiver takes it, unless the done
			// state refills it in the same cycle
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						stat_q    <= STAT_OK;
						ord_q     <= ORD_EARLIER;
						wm_q      <= stored_month_q;
						wy_q      <= stored_year_q;
						wr_q      <= stored_r_q;
						g_day_q   <= in_day;
						g_month_q <= in_month;
						g_year_q  <= in_year;
						case (in_mode)
							MODE_SET: begin
								state_q <= ST_YMOD;
							end
							MODE_NEXT: begin
								wd_q    <= sd_ext + DAY_ONE;
								state_q <= ST_FWD;
							end
							MODE_PREV: begin
								wd_q    <= sd_ext - DAY_ONE;
								state_q <= ST_BWD;
							end
							MODE_ADD: begin
								wd_q    <= sd_ext + cnt_ext;
								state_q <= ST_FWD;
							end
							MODE_SUB: begin
								wd_q    <= sd_ext - cnt_ext;
								state_q <= ST_BWD;
							end
							MODE_CMP: begin
								ord_q   <= cmp_ord;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end

				ST_YMOD: begin
					if (ymod_done) begin
						if (set_ok) begin
							stored_day_q   <= g_day_q;
							stored_month_q <= g_month_q;
							stored_year_q  <= g_year_q;
							stored_r_q     <= ymod_rem;
						end else begin
							stat_q <= STAT_INVALID;
						end
						state_q <= ST_DONE;
					end
				end

				ST_FWD: begin
					if (fwd_more) begin
						wd_q <= wd_q - fwd_len_s;
						if (wm_q == MONTH_DEC) begin
							if (fwd_over) begin
								stat_q  <= STAT_RANGE;
								state_q <= ST_DONE;
							end else begin
								wm_q <= MONTH_JAN;
								wy_q <= wy_inc[YEAR_W-1:0];
								wr_q <= wr_inc;
							end
						end else begin
							wm_q <= wm_q + MONTH_JAN;
						end
					end else begin
						stored_day_q   <= wd_q[DAY_W-1:0];
						stored_month_q <= wm_q;
						stored_year_q  <= wy_q;
						stored_r_q     <= wr_q;
						state_q        <= ST_DONE;
					end
				end

				ST_BWD: begin
					if (bwd_more) begin
						if (bwd_wrap && (wy_q <= YEAR_ONE)) begin
							stat_q  <= STAT_RANGE;
							state_q <= ST_DONE;
						end else begin
							wm_q <= bwd_month;
							wd_q <= wd_q + bwd_len_s;
							if (bwd_wrap) begin
								wy_q <= wy_q - YEAR_ONE;
								wr_q <= wr_dec;
							end
						end
					end else begin
						stored_day_q   <= wd_q[DAY_W-1:0];
						stored_month_q <= wm_q;
						stored_year_q  <= wy_q;
						stored_r_q     <= wr_q;
						state_q        <= ST_DONE;
					end
				end

				ST_DONE: begin
					// Hold until the output register is free or draining
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {5'b00000, ord_q, stat_q, stored_year_q,
							stored_month_q, stored_day_q};
						state_q    <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTH
	a_stored_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(stored_month_q >= MONTH_JAN) && (stored_month_q <= MONTH_DEC) &&
		(stored_day_q != '0))
		else $error("stored date holds an impossible month or day");

	a_work_month: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FWD || state_q == ST_BWD) |->
		(wm_q >= MONTH_JAN) && (wm_q <= MONTH_DEC))
		else $error("working month left 1..12 during a walk");

	a_fwd_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FWD) |-> (wd_q >= DAY_ONE))
		else $error("forward walk reached a day below one");

	a_ymod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(stored_r_q <= YEAR_CYCLE_LAST) && (wr_q <= YEAR_CYCLE_LAST))
		else $error("year residue out of the 400 year cycle");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");
`endif

endmodule

[design/cda_ymod.sv]
// Iterative year reduction modulo 400 by shifted compare-and-subtract.
module cda_ymod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cda_pkg::YEAR_W-1:0] year,
	output logic                       done,
	output logic [cda_pkg::YMOD_W-1:0] rem
);
	import cda_pkg::*;

	logic [YEAR_W-1:0] rem_q;
	logic [2:0]        k_q;
	logic              busy_q;
	logic              done_q;
	logic [YEAR_W:0]   step_val;
	logic              ge;

	assign step_val = (YEAR_W + 1)'(YEAR_CYCLE) << k_q;
	assign ge       = {1'b0, rem_q} >= step_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			k_q    <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= year;
			k_q    <= 3'(YMOD_TOP_SHIFT);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - step_val[YEAR_W-1:0];
			end
			if (k_q == 3'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				k_q <= k_q - 3'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign rem  = rem_q[YMOD_W-1:0];

endmodule
